// ----- rtl/core/i2cbc_pkg.sv -----
// Shared types, register indexes and reset values for the I2C bus clear sequencer.
package i2cbc_pkg;

   localparam int unsigned CsrAddrW = 2;
   localparam int unsigned CsrDataW = 8;

   localparam logic [CsrAddrW-1:0] CSR_SCL_WAIT_LIMIT = 2'd0;
   localparam logic [CsrAddrW-1:0] CSR_MAX_PULSES     = 2'd1;
   localparam logic [CsrAddrW-1:0] CSR_SETTLE_TICKS   = 2'd2;

   localparam logic [7:0] SCL_WAIT_LIMIT_RST = 8'd10;
   localparam logic [3:0] MAX_PULSES_RST     = 4'd9;
   localparam logic [7:0] SETTLE_TICKS_RST   = 8'd1;

   typedef enum logic [3:0] {
      PH_IDLE      = 4'd0,
      PH_SET0      = 4'd1,
      PH_WAIT0     = 4'd2,
      PH_LOW       = 4'd3,
      PH_PWAIT     = 4'd4,
      PH_PSET      = 4'd5,
      PH_STOP_LOW  = 4'd6,
      PH_STOP_WAIT = 4'd7,
      PH_STOP_SET  = 4'd8,
      PH_STOP_REL  = 4'd9
   } phase_type;

   typedef struct packed {
      logic [7:0] scl_wait_limit;
      logic [3:0] max_pulses;
      logic [7:0] settle_ticks;
   } cfg_type;

   typedef struct packed {
      phase_type  phase;
      logic [7:0] wait_count;
      logic [7:0] settle_count;
      logic [3:0] pulse_count;
      logic       clock_ok;
      logic       scl_free;
      logic       sda_free;
   } seq_state_type;

   typedef struct packed {
      logic scl_release;
      logic sda_release;
      logic busy;
      logic done;
      logic free_res;
   } seq_result_type;

endpackage

// ----- rtl/core/i2cbc_step.sv -----
// Next-state and result logic for one tick of the bus clear sequence.
module i2cbc_step import i2cbc_pkg::*; (
   input  cfg_type        cfg,
   input  seq_state_type  cur,
   input  logic           start_req,
   input  logic           scl_level,
   input  logic           sda_level,
   output seq_state_type  nxt,
   output seq_result_type res
);

   logic [7:0] settle_inc;
   logic [7:0] wait_inc;
   logic       settle_end;
   logic       scl_stuck;
   logic       more_pulses;
   logic       done;
   logic       free_flag;

   always_comb begin
      settle_inc  = cur.settle_count + 8'd1;
      wait_inc    = cur.wait_count + 8'd1;
      settle_end  = (settle_inc >= cfg.settle_ticks);
      scl_stuck   = !scl_level && (cur.wait_count >= cfg.scl_wait_limit);
      more_pulses = !sda_level && (cur.pulse_count < cfg.max_pulses);
      done        = 1'b0;
      free_flag   = 1'b0;
      nxt         = cur;

      case (cur.phase)
         PH_IDLE: begin
            nxt.scl_free = 1'b1;
            nxt.sda_free = 1'b1;
            if (start_req) begin
               nxt.wait_count   = '0;
               nxt.settle_count = '0;
               nxt.pulse_count  = '0;
               nxt.clock_ok     = 1'b1;
               nxt.phase        = PH_SET0;
            end
         end
         PH_SET0, PH_LOW, PH_PSET, PH_STOP_LOW, PH_STOP_SET, PH_STOP_REL: begin
            nxt.settle_count = settle_end ? 8'd0 : settle_inc;
            if (settle_end) begin
               case (cur.phase)
                  PH_SET0: begin
                     nxt.wait_count = '0;
                     nxt.phase      = PH_WAIT0;
                  end
                  PH_LOW: begin
                     nxt.scl_free   = 1'b1;
                     nxt.wait_count = '0;
                     nxt.phase      = PH_PWAIT;
                  end
                  PH_STOP_LOW: begin
                     nxt.scl_free   = 1'b1;
                     nxt.wait_count = '0;
                     nxt.phase      = PH_STOP_WAIT;
                  end
                  PH_STOP_SET: begin
                     nxt.sda_free = 1'b1;
                     nxt.phase    = PH_STOP_REL;
                  end
                  PH_STOP_REL: begin
                     done      = 1'b1;
                     free_flag = cur.clock_ok & sda_level;
                  end
                  default: begin
                     // PH_PSET: clock is high, decide on another pulse or STOP
                     nxt.settle_count = '0;
                     nxt.scl_free     = 1'b0;
                     if (more_pulses) begin
                        nxt.pulse_count = cur.pulse_count + 4'd1;
                        nxt.phase       = PH_LOW;
                     end else begin
                        nxt.sda_free = 1'b0;
                        nxt.phase    = PH_STOP_LOW;
                     end
                  end
               endcase
            end
         end
         PH_WAIT0, PH_PWAIT: begin
            if (scl_level) begin
               nxt.wait_count   = '0;
               nxt.settle_count = '0;
               if (cur.phase == PH_WAIT0) begin
                  nxt.scl_free = 1'b0;
                  if (more_pulses) begin
                     nxt.pulse_count = cur.pulse_count + 4'd1;
                     nxt.phase       = PH_LOW;
                  end else begin
                     nxt.sda_free = 1'b0;
                     nxt.phase    = PH_STOP_LOW;
                  end
               end else begin
                  nxt.phase = PH_PSET;
               end
            end else if (scl_stuck) begin
               nxt.wait_count = '0;
               nxt.clock_ok   = 1'b0;
               done           = 1'b1;
            end else begin
               nxt.wait_count = wait_inc;
            end
         end
         PH_STOP_WAIT: begin
            if (scl_level || scl_stuck) begin
               // a stuck clock still finishes the STOP, only marks the failure
               if (!scl_level) nxt.clock_ok = 1'b0;
               nxt.wait_count   = '0;
               nxt.settle_count = '0;
               nxt.phase        = PH_STOP_SET;
            end else begin
               nxt.wait_count = wait_inc;
            end
         end
         default: begin
            nxt.phase    = PH_IDLE;
            nxt.scl_free = 1'b1;
            nxt.sda_free = 1'b1;
         end
      endcase

      if (done) begin
         nxt.phase        = PH_IDLE;
         nxt.scl_free     = 1'b1;
         nxt.sda_free     = 1'b1;
         nxt.wait_count   = '0;
         nxt.settle_count = '0;
      end

      res.scl_release = nxt.scl_free;
      res.sda_release = nxt.sda_free;
      res.busy        = (nxt.phase != PH_IDLE);
      res.done        = done;
      res.free_res    = free_flag;
   end

endmodule

// ----- rtl/core/i2c_bus_clear_sequencer.sv -----
// Top level of the I2C bus clear sequencer: config registers, sequence state, result register.
//
//   channel | direction | fields                                        | handshake
//   req     | in        | start_req scl_level sda_level                 | req_valid/req_ready
//   rsp     | out       | scl_release sda_release busy_res done_res     | rsp_valid/rsp_ready
//           |           | free_res                                      |
//   csr     | in        | csr_addr csr_wdata                            | csr_we, no wait
//
// One request per cycle: each accepted tick updates the sequence state and loads one
// result into the output register in the same cycle. req_ready is high while the
// output register is empty or being drained, so a stalled rsp side holds one result
// and stops requests; nothing else stalls. Synchronous reset puts the sequencer idle
// with both lines released and restores the register reset values.
module i2c_bus_clear_sequencer import i2cbc_pkg::*; (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   input  logic                req_start_req,
   input  logic                req_scl_level,
   input  logic                req_sda_level,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output logic                rsp_scl_release,
   output logic                rsp_sda_release,
   output logic                rsp_busy_res,
   output logic                rsp_done_res,
   output logic                rsp_free_res,
   input  logic                csr_we,
   input  logic [CsrAddrW-1:0] csr_addr,
   input  logic [CsrDataW-1:0] csr_wdata
);

   cfg_type        cfg_ff;
   seq_state_type  state_ff;
   seq_state_type  state_in;
   seq_result_type res_ff;
   seq_result_type res_in;
   logic           rsp_valid_ff;
   logic           req_take;

   assign req_ready = !rsp_valid_ff || rsp_ready;
   assign req_take  = req_valid && req_ready;

   i2cbc_step u_step (
      .cfg       (cfg_ff),
      .cur       (state_ff),
      .start_req (req_start_req),
      .scl_level (req_scl_level),
      .sda_level (req_sda_level),
      .nxt       (state_in),
      .res       (res_in)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.scl_wait_limit <= SCL_WAIT_LIMIT_RST;
         cfg_ff.max_pulses     <= MAX_PULSES_RST;
         cfg_ff.settle_ticks   <= SETTLE_TICKS_RST;
      end else if (csr_we) begin
         case (csr_addr)
            CSR_SCL_WAIT_LIMIT: cfg_ff.scl_wait_limit <= csr_wdata;
            CSR_MAX_PULSES:     cfg_ff.max_pulses     <= csr_wdata[3:0];
            CSR_SETTLE_TICKS:   cfg_ff.settle_ticks   <= csr_wdata;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff.phase        <= PH_IDLE;
         state_ff.wait_count   <= '0;
         state_ff.settle_count <= '0;
         state_ff.pulse_count  <= '0;
         state_ff.clock_ok     <= 1'b1;
         state_ff.scl_free     <= 1'b1;
         state_ff.sda_free     <= 1'b1;
      end else if (req_take) begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (req_take) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   // payload only, no reset needed
   always_ff @(posedge clock) begin
      if (req_take) begin
         res_ff <= res_in;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_scl_release = res_ff.scl_release;
   assign rsp_sda_release = res_ff.sda_release;
   assign rsp_busy_res    = res_ff.busy;
   assign rsp_done_res    = res_ff.done;
   assign rsp_free_res    = res_ff.free_res;

   a_free_needs_done: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_free_res |-> rsp_done_res)
      else $error("free flag reported without done");

   a_done_releases: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_done_res |-> rsp_scl_release && rsp_sda_release && !rsp_busy_res)
      else $error("done result with a line still driven or busy set");

   a_idle_released: assert property (@(posedge clock) disable iff (reset)
      state_ff.phase == PH_IDLE |-> state_ff.scl_free && state_ff.sda_free)
      else $error("idle sequencer is driving a line");

   a_result_tracks_state: assert property (@(posedge clock) disable iff (reset)
      req_take |=> rsp_busy_res == (state_ff.phase != PH_IDLE))
      else $error("busy result disagrees with sequence phase");

endmodule

// ----- verif/i2c_bus_clear_sequencer_tb.sv -----
// Self-checking testbench for the I2C bus clear sequencer: random ticks, timing predictor.
module i2c_bus_clear_sequencer_tb;
   timeunit 1ns;
   timeprecision 1ps;

   import i2cbc_pkg::*;

   localparam int CYCLE_LIMIT = 200000;
   localparam int REPORT_MAX  = 10;

   typedef struct packed {
      logic start;
      logic scl;
      logic sda;
   } bus_tick_type;

   typedef enum logic [1:0] {
      SCL_WAITING,
      SCL_ROSE,
      SCL_STUCK
   } scl_wait_type;

   logic                clock = 1'b0;
   logic                reset = 1'b1;
   logic                req_valid = 1'b0;
   logic                req_ready;
   logic                req_start_req = 1'b0;
   logic                req_scl_level = 1'b1;
   logic                req_sda_level = 1'b1;
   logic                rsp_valid;
   logic                rsp_ready = 1'b0;
   logic                rsp_scl_release;
   logic                rsp_sda_release;
   logic                rsp_busy_res;
   logic                rsp_done_res;
   logic                rsp_free_res;
   logic                csr_we = 1'b0;
   logic [CsrAddrW-1:0] csr_addr = '0;
   logic [CsrDataW-1:0] csr_wdata = '0;

   bus_tick_type   pending_ticks[$];
   seq_result_type bus_results[$];

   cfg_type        cfg = {SCL_WAIT_LIMIT_RST, MAX_PULSES_RST, SETTLE_TICKS_RST};
   seq_state_type  bus_st;

   int unsigned    queued_ticks = 0;
   int unsigned    accepted_ticks = 0;
   int unsigned    mismatches = 0;
   int unsigned    cycle_count = 0;
   int unsigned    hold_left = 0;
   logic           hold_used = 1'b0;

   i2c_bus_clear_sequencer uut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_start_req   (req_start_req),
      .req_scl_level   (req_scl_level),
      .req_sda_level   (req_sda_level),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_scl_release (rsp_scl_release),
      .rsp_sda_release (rsp_sda_release),
      .rsp_busy_res    (rsp_busy_res),
      .rsp_done_res    (rsp_done_res),
      .rsp_free_res    (rsp_free_res),
      .csr_we          (csr_we),
      .csr_addr        (csr_addr),
      .csr_wdata       (csr_wdata)
   );

   always #1 clock = ~clock;

   // ---------------------------------------------------------------- predictor

   function automatic logic settle_elapsed();
      bus_st.settle_count = bus_st.settle_count + 8'd1;
      if (bus_st.settle_count >= cfg.settle_ticks) begin
         bus_st.settle_count = '0;
         return 1'b1;
      end
      return 1'b0;
   endfunction

   function automatic scl_wait_type sample_scl(input logic scl);
      if (scl) begin
         bus_st.wait_count = '0;
         return SCL_ROSE;
      end
      if (bus_st.wait_count >= cfg.scl_wait_limit) begin
         bus_st.wait_count = '0;
         return SCL_STUCK;
      end
      bus_st.wait_count = bus_st.wait_count + 8'd1;
      return SCL_WAITING;
   endfunction

   // clock is high again: another recovery pulse while SDA is low, else STOP
   function automatic void next_pulse_or_stop(input logic sda);
      bus_st.scl_free = 1'b0;
      bus_st.settle_count = '0;
      if (!sda && bus_st.pulse_count < cfg.max_pulses) begin
         bus_st.pulse_count = bus_st.pulse_count + 4'd1;
         bus_st.phase = PH_LOW;
      end else begin
         bus_st.sda_free = 1'b0;
         bus_st.phase = PH_STOP_LOW;
      end
   endfunction

   function automatic seq_result_type recovery_step(input bus_tick_type t);
      seq_result_type r;
      scl_wait_type   w;
      logic           done;
      logic           free_flag;
      done = 1'b0;
      free_flag = 1'b0;
      case (bus_st.phase)
         PH_IDLE: begin
            bus_st.scl_free = 1'b1;
            bus_st.sda_free = 1'b1;
            if (t.start) begin
               bus_st.wait_count = '0;
               bus_st.settle_count = '0;
               bus_st.pulse_count = '0;
               bus_st.clock_ok = 1'b1;
               bus_st.phase = PH_SET0;
            end
         end
         PH_SET0: begin
            if (settle_elapsed()) begin
               bus_st.wait_count = '0;
               bus_st.phase = PH_WAIT0;
            end
         end
         PH_WAIT0, PH_PWAIT: begin
            w = sample_scl(t.scl);
            if (w == SCL_ROSE) begin
               if (bus_st.phase == PH_WAIT0) begin
                  next_pulse_or_stop(t.sda);
               end else begin
                  bus_st.settle_count = '0;
                  bus_st.phase = PH_PSET;
               end
            end else if (w == SCL_STUCK) begin
               bus_st.clock_ok = 1'b0;
               done = 1'b1;
            end
         end
         PH_LOW: begin
            if (settle_elapsed()) begin
               bus_st.scl_free = 1'b1;
               bus_st.wait_count = '0;
               bus_st.phase = PH_PWAIT;
            end
         end
         PH_PSET: begin
            if (settle_elapsed()) next_pulse_or_stop(t.sda);
         end
         PH_STOP_LOW: begin
            if (settle_elapsed()) begin
               bus_st.scl_free = 1'b1;
               bus_st.wait_count = '0;
               bus_st.phase = PH_STOP_WAIT;
            end
         end
         PH_STOP_WAIT: begin
            // a stuck clock here still finishes the STOP, only the free flag is lost
            w = sample_scl(t.scl);
            if (w != SCL_WAITING) begin
               if (w == SCL_STUCK) bus_st.clock_ok = 1'b0;
               bus_st.settle_count = '0;
               bus_st.phase = PH_STOP_SET;
            end
         end
         PH_STOP_SET: begin
            if (settle_elapsed()) begin
               bus_st.sda_free = 1'b1;
               bus_st.phase = PH_STOP_REL;
            end
         end
         PH_STOP_REL: begin
            if (settle_elapsed()) begin
               done = 1'b1;
               free_flag = bus_st.clock_ok & t.sda;
            end
         end
         default: begin
            bus_st.phase = PH_IDLE;
            bus_st.scl_free = 1'b1;
            bus_st.sda_free = 1'b1;
         end
      endcase
      if (done) begin
         bus_st.phase = PH_IDLE;
         bus_st.scl_free = 1'b1;
         bus_st.sda_free = 1'b1;
         bus_st.wait_count = '0;
         bus_st.settle_count = '0;
      end
      r.scl_release = bus_st.scl_free;
      r.sda_release = bus_st.sda_free;
      r.busy = (bus_st.phase != PH_IDLE);
      r.done = done;
      r.free_res = free_flag;
      return r;
   endfunction

   // ---------------------------------------------------------------- request driver

   int burst_left = 0;
   int gap_left = 0;

   always @(posedge clock) begin
      bus_tick_type t;
      if (reset) begin
         req_valid <= 1'b0;
         bus_st = '0;
         bus_st.phase = PH_IDLE;
         bus_st.clock_ok = 1'b1;
         bus_st.scl_free = 1'b1;
         bus_st.sda_free = 1'b1;
      end else begin
         if (req_valid && req_ready) begin
            t = {req_start_req, req_scl_level, req_sda_level};
            bus_results.push_back(recovery_step(t));
            accepted_ticks++;
         end
         // only move on once the current request is gone
         if (!req_valid || req_ready) begin
            if (gap_left != 0) begin
               gap_left--;
               req_valid <= 1'b0;
            end else if (pending_ticks.size() != 0) begin
               t = pending_ticks.pop_front();
               req_valid <= 1'b1;
               req_start_req <= t.start;
               req_scl_level <= t.scl;
               req_sda_level <= t.sda;
               if (burst_left == 0) begin
                  burst_left = $urandom_range(1, 30);
                  gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
               end else begin
                  burst_left--;
               end
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // ---------------------------------------------------------------- response side

   // one long hold-off while the sender keeps offering requests
   always @(posedge clock) begin
      if (reset) begin
         hold_left <= 0;
      end else if (hold_left != 0) begin
         hold_left <= hold_left - 1;
      end else if (!hold_used && accepted_ticks >= 200 && pending_ticks.size() > 8) begin
         hold_left <= 400;
         hold_used <= 1'b1;
      end
   end

   logic [31:0] ready_bits = '1;
   int          ready_span = 0;

   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (ready_span == 0) begin
            ready_span = $urandom_range(8, 64);
            ready_bits = ($urandom_range(0, 2) == 0) ? 32'hFFFF_FFFF : $urandom;
         end
         ready_span--;
         ready_bits = {ready_bits[0], ready_bits[31:1]};
         rsp_ready <= ready_bits[0] && (hold_left == 0);
      end
   end

   always @(posedge clock) begin
      seq_result_type want;
      seq_result_type got;
      if (!reset && rsp_valid && rsp_ready) begin
         got = {rsp_scl_release, rsp_sda_release, rsp_busy_res, rsp_done_res, rsp_free_res};
         if (bus_results.size() == 0) begin
            mismatches++;
            if (mismatches <= REPORT_MAX)
               $display("unexpected response: scl=%b sda=%b busy=%b done=%b free=%b",
                        got.scl_release, got.sda_release, got.busy, got.done, got.free_res);
         end else begin
            want = bus_results.pop_front();
            if (got.scl_release !== want.scl_release || got.sda_release !== want.sda_release ||
                got.busy !== want.busy || got.done !== want.done ||
                got.free_res !== want.free_res) begin
               mismatches++;
               if (mismatches <= REPORT_MAX)
                  $display("response mismatch: expected scl=%b sda=%b busy=%b done=%b free=%b, %s",
                           want.scl_release, want.sda_release, want.busy, want.done,
                           want.free_res,
                           $sformatf("got scl=%b sda=%b busy=%b done=%b free=%b",
                                     got.scl_release, got.sda_release, got.busy, got.done,
                                     got.free_res));
            end
         end
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("FAILURE");
         $finish;
      end
   end

   // ---------------------------------------------------------------- stimulus

   task automatic push_tick(input logic start, input logic scl, input logic sda);
      pending_ticks.push_back({start, scl, sda});
      queued_ticks++;
   endtask

   task automatic wait_drained();
      while (pending_ticks.size() != 0 || req_valid || bus_results.size() != 0)
         @(posedge clock);
      repeat (2) @(posedge clock);
   endtask

   task automatic write_reg(input logic [CsrAddrW-1:0] idx, input logic [CsrDataW-1:0] data);
      @(posedge clock);
      csr_we <= 1'b1;
      csr_addr <= idx;
      csr_wdata <= data;
      case (idx)
         CSR_SCL_WAIT_LIMIT: cfg.scl_wait_limit = data;
         CSR_MAX_PULSES:     cfg.max_pulses = data[3:0];
         CSR_SETTLE_TICKS:   cfg.settle_ticks = data;
         default: ;
      endcase
      @(posedge clock);
      csr_we <= 1'b0;
   endtask

   task automatic set_config(input logic [7:0] wait_limit, input logic [7:0] pulses,
                             input logic [7:0] settle);
      write_reg(CSR_SCL_WAIT_LIMIT, wait_limit);
      write_reg(CSR_MAX_PULSES, pulses);
      write_reg(CSR_SETTLE_TICKS, settle);
   endtask

   // start, then a bus that mostly follows the sequencer: short SCL stretches,
   // SDA stuck low for a while and then free, a few stray starts while busy
   task automatic add_recovery(input int ticks, input int stretch_max);
      int   low_run;
      int   sda_hold;
      logic scl;
      low_run = 0;
      sda_hold = $urandom_range(0, ticks);
      push_tick(1'b1, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
      for (int i = 0; i < ticks; i++) begin
         if (low_run == 0 && $urandom_range(0, 7) == 0)
            low_run = $urandom_range(1, stretch_max);
         scl = (low_run == 0);
         if (low_run != 0) low_run--;
         push_tick($urandom_range(0, 15) == 0, scl,
                   (i >= sda_hold) ^ ($urandom_range(0, 19) == 0));
      end
   endtask

   task automatic add_noise(input int ticks);
      for (int i = 0; i < ticks; i++)
         push_tick(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                   1'($urandom_range(0, 1)));
   endtask

   task automatic fill_ticks(input int unsigned target, input int stretch_max);
      int unsigned stop_at;
      stop_at = queued_ticks + target;
      while (queued_ticks < stop_at) begin
         if ($urandom_range(0, 4) == 0) add_noise($urandom_range(1, 6));
         else add_recovery($urandom_range(4, 40), stretch_max);
      end
   endtask

   initial begin
      int stretch_max;
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      // full recovery at reset settings: one pulse, STOP, bus free; starts while busy
      push_tick(1'b0, 1'b0, 1'b0);
      push_tick(1'b0, 1'b1, 1'b1);
      push_tick(1'b1, 1'b1, 1'b0);
      push_tick(1'b1, 1'b1, 1'b0);
      push_tick(1'b0, 1'b1, 1'b0);
      push_tick(1'b0, 1'b0, 1'b0);
      push_tick(1'b0, 1'b0, 1'b0);
      push_tick(1'b0, 1'b1, 1'b0);
      push_tick(1'b0, 1'b1, 1'b1);
      push_tick(1'b0, 1'b0, 1'b1);
      push_tick(1'b0, 1'b1, 1'b1);
      push_tick(1'b0, 1'b1, 1'b1);
      push_tick(1'b1, 1'b1, 1'b1);
      // clock held low through the whole first wait
      push_tick(1'b1, 1'b1, 1'b1);
      push_tick(1'b0, 1'b1, 1'b1);
      repeat (11) push_tick(1'b0, 1'b0, 1'b0);
      wait_drained();

      // zero registers: single-sample wait, no pulses, one-tick settle
      set_config(8'd0, 8'd0, 8'd0);
      push_tick(1'b1, 1'b0, 1'b0);
      push_tick(1'b0, 1'b0, 1'b0);
      push_tick(1'b0, 1'b0, 1'b0);
      push_tick(1'b1, 1'b1, 1'b0);
      push_tick(1'b0, 1'b1, 1'b0);
      push_tick(1'b0, 1'b1, 1'b0);
      push_tick(1'b0, 1'b0, 1'b0);
      push_tick(1'b0, 1'b0, 1'b1);
      push_tick(1'b0, 1'b0, 1'b0);
      push_tick(1'b0, 1'b1, 1'b1);
      wait_drained();

      for (int ph = 0; ph < 10; ph++) begin
         case (ph)
            0: set_config(8'd1, 8'd1, 8'd1);
            1: set_config(8'd255, 8'd15, 8'd255);
            2: set_config(8'd0, 8'd15, 8'd0);
            3: set_config(8'd2, 8'hFF, 8'd1);
            default: set_config(8'($urandom_range(0, 12)), 8'($urandom_range(0, 255)),
                                8'($urandom_range(0, 3)));
         endcase
         stretch_max = (cfg.scl_wait_limit > 17) ? 20 : cfg.scl_wait_limit + 3;
         fill_ticks(14, stretch_max);
         // hold the sender until the block has answered everything
         if (ph == 4) wait_drained();
         fill_ticks(13, stretch_max);
         wait_drained();
      end

      repeat (10) @(posedge clock);
      if (mismatches == 0 && bus_results.size() == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

endmodule
